// ----- hdl/bab_pkg.sv -----
// Shared codes and controller/datapath interface types for the block allocator.
`default_nettype none

package bab_pkg;

    // request modes
    localparam logic [2:0] MODE_ALLOC    = 3'd0;
    localparam logic [2:0] MODE_FREE     = 3'd1;
    localparam logic [2:0] MODE_USED     = 3'd2;
    localparam logic [2:0] MODE_BEGIN    = 3'd3;
    localparam logic [2:0] MODE_ROLLBACK = 3'd4;
    localparam logic [2:0] MODE_QUERY    = 3'd5;

    // result status
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FREE   = 2'd1;
    localparam logic [1:0] ST_LIST_FULL = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    localparam logic [12:0] TOTAL_RST = 13'd4096;
    localparam logic [12:0] USED_MAX  = 13'h1FFF;

    // datapath operations
    localparam logic [3:0] OP_NONE  = 4'd0;
    localparam logic [3:0] OP_CLR   = 4'd1;
    localparam logic [3:0] OP_SCAN  = 4'd2;
    localparam logic [3:0] OP_MK_RD = 4'd3;
    localparam logic [3:0] OP_MK_WR = 4'd4;
    localparam logic [3:0] OP_RB_CL = 4'd5;
    localparam logic [3:0] OP_RB_BM = 4'd6;
    localparam logic [3:0] OP_RB_WR = 4'd7;
    localparam logic [3:0] OP_FIN   = 4'd8;

    typedef struct packed {
        logic       load;
        logic [3:0] op;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic fin;
    } t_sts;

endpackage

`default_nettype wire

// ----- hdl/bab_ctrl.sv -----
// Sequencer for the block allocator: steps each request through the datapath.
`default_nettype none

module bab_ctrl import bab_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [2:0] i_mode,
    input  wire t_sts       i_sts,
    output t_cmd            o_cmd,
    output logic            o_busy
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_MK_RD = 4'd3;
    localparam logic [3:0] S_MK_WR = 4'd4;
    localparam logic [3:0] S_RB_CL = 4'd5;
    localparam logic [3:0] S_RB_BM = 4'd6;
    localparam logic [3:0] S_RB_WR = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.op   = OP_NONE;
        unique case (r_state)
            S_CLR: begin
                o_cmd.op = OP_CLR;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    unique case (i_mode) inside
                        MODE_ALLOC:                        n_state = S_SCAN;
                        MODE_FREE, MODE_USED, MODE_QUERY:  n_state = S_MK_RD;
                        MODE_ROLLBACK:                     n_state = S_RB_CL;
                        default:                           n_state = S_FIN;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.op = OP_SCAN;
                if (i_sts.fin) n_state = S_IDLE;
            end
            S_MK_RD: begin
                o_cmd.op = OP_MK_RD;
                n_state  = i_sts.fin ? S_IDLE : S_MK_WR;
            end
            S_MK_WR: begin
                o_cmd.op = OP_MK_WR;
                n_state  = S_IDLE;
            end
            S_RB_CL: begin
                o_cmd.op = OP_RB_CL;
                n_state  = i_sts.fin ? S_IDLE : S_RB_BM;
            end
            S_RB_BM: begin
                o_cmd.op = OP_RB_BM;
                n_state  = S_RB_WR;
            end
            S_RB_WR: begin
                o_cmd.op = OP_RB_WR;
                n_state  = i_sts.fin ? S_IDLE : S_RB_BM;
            end
            S_FIN: begin
                o_cmd.op = OP_FIN;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.fin |=> (r_state == S_IDLE))
        else $error("request finished but sequencer did not return to idle");

    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> ($past(i_sts.fin) || $past(i_sts.clr_last)))
        else $error("busy dropped without a finished request or clearing pass");

endmodule

`default_nettype wire

// ----- hdl/bab_dpath.sv -----
// Datapath of the block allocator: bitmap and claim memories, counters, result registers.
`default_nettype none

module bab_dpath import bab_pkg::*; #(
    parameter int NUM_BLOCKS      = 4096,
    parameter int MAX_FILE_BLOCKS = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic [2:0]  i_mode,
    input  wire logic [11:0] i_block_number,
    input  wire logic        i_cfg_we,
    input  wire logic [12:0] i_cfg_data,
    output logic             o_res_vld,
    output logic [11:0]      o_allocated_block,
    output logic [1:0]       o_status,
    output logic             o_block_is_used,
    output logic [12:0]      o_used_count
);

    localparam int WORDS = (NUM_BLOCKS + 63) / 64;
    localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int AC_W  = WA_W + 1;
    localparam int BLK_W = (NUM_BLOCKS > 4096) ? $clog2(NUM_BLOCKS) : 12;
    localparam int CMP_W = BLK_W + 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int UX_W  = (CNT_W > 13) ? CNT_W : 13;
    localparam int CD    = MAX_FILE_BLOCKS + 1;
    localparam int CA_W  = $clog2(CD);
    localparam int CC_W  = $clog2(CD + 1);

    // memories
    logic [63:0]      r_bitmap [WORDS];
    logic [BLK_W-1:0] r_claims [CD];
    logic [63:0]      r_word;
    logic [BLK_W-1:0] r_claim_q;

    // control registers
    logic [AC_W-1:0]  r_addr, n_addr;
    logic [AC_W-1:0]  r_ev, n_ev;
    logic             r_ev_vld, n_ev_vld;
    logic [CC_W-1:0]  r_rb_idx, n_rb_idx;
    logic [CC_W-1:0]  r_claim_cnt, n_claim_cnt;
    logic [CNT_W-1:0] r_used, n_used;
    logic [12:0]      r_total;
    logic             r_res_vld;

    // request registers
    logic [2:0]       r_mode;
    logic [11:0]      r_blk;
    logic [CMP_W-1:0] r_lim;

    // result registers
    logic [BLK_W-1:0] r_grant;
    logic [1:0]       r_status;
    logic             r_bit;
    logic [12:0]      r_used_q;

    logic             bm_we, bm_re, cl_we, cl_re;
    logic [WA_W-1:0]  bm_waddr, bm_raddr;
    logic [63:0]      bm_wdata;
    logic [CA_W-1:0]  cl_waddr, cl_raddr;
    logic [BLK_W-1:0] cl_wdata;

    logic             emit, fin;
    logic [BLK_W-1:0] e_grant;
    logic [1:0]       e_status;
    logic             e_bit;
    logic [12:0]      used_sat;

    logic [CMP_W-1:0] tot_x, eff_lim, ev_base, cand_x, blk_cmp;
    logic [63:0]      free_bits, iso;
    logic [5:0]       idx;
    logic [BLK_W-1:0] cand_blk, blk_x;
    logic [63:0]      blk_mask, cl_mask;
    logic             blk_oob;

    assign tot_x   = CMP_W'(r_total);
    assign eff_lim = (tot_x < CMP_W'(NUM_BLOCKS)) ? tot_x : CMP_W'(NUM_BLOCKS);

    // lowest free bit of the word under evaluation
    assign free_bits = ~r_word;
    assign iso       = free_bits & (~free_bits + 64'd1);
    always_comb begin
        idx = '0;
        for (int i = 0; i < 64; i++) begin
            if (iso[i]) idx = idx | 6'(i);
        end
    end

    assign ev_base  = CMP_W'({r_ev, 6'b0});
    assign cand_blk = BLK_W'({r_ev[WA_W-1:0], idx});
    assign cand_x   = CMP_W'(cand_blk);

    assign blk_x    = BLK_W'(r_blk);
    assign blk_cmp  = CMP_W'(r_blk);
    assign blk_oob  = (blk_cmp >= r_lim);
    assign blk_mask = 64'd1 << r_blk[5:0];
    assign cl_mask  = 64'd1 << r_claim_q[5:0];

    always_comb begin
        n_addr      = r_addr;
        n_ev        = r_ev;
        n_ev_vld    = r_ev_vld;
        n_rb_idx    = r_rb_idx;
        n_claim_cnt = r_claim_cnt;
        n_used      = r_used;
        bm_we       = 1'b0;
        bm_waddr    = r_ev[WA_W-1:0];
        bm_wdata    = r_word;
        bm_re       = 1'b0;
        bm_raddr    = r_addr[WA_W-1:0];
        cl_we       = 1'b0;
        cl_waddr    = r_claim_cnt[CA_W-1:0];
        cl_wdata    = cand_blk;
        cl_re       = 1'b0;
        cl_raddr    = r_rb_idx[CA_W-1:0];
        emit        = 1'b0;
        fin         = 1'b0;
        e_grant     = '0;
        e_status    = ST_OK;
        e_bit       = 1'b0;

        if (i_cmd.load) begin
            n_addr   = '0;
            n_ev_vld = 1'b0;
            n_rb_idx = '0;
        end

        unique case (i_cmd.op)
            OP_CLR: begin
                bm_we    = 1'b1;
                bm_waddr = r_addr[WA_W-1:0];
                bm_wdata = '0;
                n_addr   = r_addr + 1'b1;
            end
            OP_SCAN: begin
                // read one word per cycle, evaluate the word read the cycle before
                bm_re    = (r_addr < AC_W'(WORDS));
                n_addr   = r_addr + 1'b1;
                n_ev     = r_addr;
                n_ev_vld = 1'b1;
                if (r_ev_vld) begin
                    if (ev_base >= r_lim) begin
                        emit     = 1'b1;
                        fin      = 1'b1;
                        e_status = ST_NO_FREE;
                    end else if (free_bits != '0) begin
                        emit = 1'b1;
                        fin  = 1'b1;
                        if (cand_x >= r_lim) begin
                            e_status = ST_NO_FREE;
                        end else if (r_claim_cnt >= CC_W'(CD)) begin
                            e_status = ST_LIST_FULL;
                        end else begin
                            bm_we       = 1'b1;
                            bm_wdata    = r_word | iso;
                            cl_we       = 1'b1;
                            n_claim_cnt = r_claim_cnt + 1'b1;
                            n_used      = r_used + 1'b1;
                            e_grant     = cand_blk;
                            e_bit       = 1'b1;
                        end
                    end
                end
            end
            OP_MK_RD: begin
                if (blk_oob) begin
                    emit     = 1'b1;
                    fin      = 1'b1;
                    e_status = ST_RANGE;
                end else begin
                    bm_re    = 1'b1;
                    bm_raddr = blk_x[6 +: WA_W];
                end
            end
            OP_MK_WR: begin
                bm_waddr = blk_x[6 +: WA_W];
                emit     = 1'b1;
                fin      = 1'b1;
                unique case (r_mode)
                    MODE_FREE: begin
                        if ((r_word & blk_mask) != '0) begin
                            bm_we    = 1'b1;
                            bm_wdata = r_word & ~blk_mask;
                            n_used   = r_used - 1'b1;
                        end
                    end
                    MODE_USED: begin
                        e_bit = 1'b1;
                        if ((r_word & blk_mask) == '0) begin
                            bm_we    = 1'b1;
                            bm_wdata = r_word | blk_mask;
                            n_used   = r_used + 1'b1;
                        end
                    end
                    default: e_bit = ((r_word & blk_mask) != '0);
                endcase
            end
            OP_RB_CL: begin
                if (r_claim_cnt == '0) begin
                    emit = 1'b1;
                    fin  = 1'b1;
                end else begin
                    cl_re    = 1'b1;
                    n_rb_idx = r_rb_idx + 1'b1;
                end
            end
            OP_RB_BM: begin
                bm_re    = 1'b1;
                bm_raddr = r_claim_q[6 +: WA_W];
            end
            OP_RB_WR: begin
                // only claims still marked used are released
                bm_waddr = r_claim_q[6 +: WA_W];
                if ((r_word & cl_mask) != '0) begin
                    bm_we    = 1'b1;
                    bm_wdata = r_word & ~cl_mask;
                    n_used   = r_used - 1'b1;
                end
                if (r_rb_idx < r_claim_cnt) begin
                    cl_re    = 1'b1;
                    n_rb_idx = r_rb_idx + 1'b1;
                end else begin
                    n_claim_cnt = '0;
                    emit        = 1'b1;
                    fin         = 1'b1;
                end
            end
            OP_FIN: begin
                if (r_mode == MODE_BEGIN) n_claim_cnt = '0;
                emit = 1'b1;
                fin  = 1'b1;
            end
            default: ;
        endcase
    end

    assign used_sat = (UX_W'(n_used) > UX_W'(USED_MAX)) ? USED_MAX : 13'(n_used);

    assign o_sts.fin      = fin;
    assign o_sts.clr_last = (i_cmd.op == OP_CLR) && (r_addr == AC_W'(WORDS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_ev_vld    <= 1'b0;
            r_rb_idx    <= '0;
            r_claim_cnt <= '0;
            r_used      <= '0;
            r_total     <= TOTAL_RST;
            r_res_vld   <= 1'b0;
        end else begin
            r_addr      <= n_addr;
            r_ev_vld    <= n_ev_vld;
            r_rb_idx    <= n_rb_idx;
            r_claim_cnt <= n_claim_cnt;
            r_used      <= n_used;
            r_res_vld   <= emit;
            if (i_cfg_we) r_total <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev <= n_ev;
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_blk  <= i_block_number;
            r_lim  <= eff_lim;
        end
        if (emit) begin
            r_grant  <= e_grant;
            r_status <= e_status;
            r_bit    <= e_bit;
            r_used_q <= used_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (bm_we) r_bitmap[bm_waddr] <= bm_wdata;
        if (bm_re) r_word <= r_bitmap[bm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (cl_we) r_claims[cl_waddr] <= cl_wdata;
        if (cl_re) r_claim_q <= r_claims[cl_raddr];
    end

    assign o_res_vld         = r_res_vld;
    assign o_allocated_block = r_grant[11:0];
    assign o_status          = r_status;
    assign o_block_is_used   = r_bit;
    assign o_used_count      = r_used_q;

    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld |=> !r_res_vld)
        else $error("two result strobes in consecutive cycles");

    a_claim_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_claim_cnt <= CC_W'(CD))
        else $error("claim count beyond list depth");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(NUM_BLOCKS))
        else $error("used count beyond block count");

    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_vld && (r_status != ST_OK)) |-> (r_grant == '0))
        else $error("block granted with failing status");

endmodule

`default_nettype wire

// ----- hdl/bitmap_block_allocator_rollback.sv -----
// Top level of the first-fit bitmap block allocator with claim rollback.
// Begin and unknown modes finish through a single FIN state. Mark and query read the bitmap
// word, then mark modes may write it back (out-of-range blocks end at the read). Allocate
// scans from word 0, one bitmap word read per cycle. Rollback reads each claim, then its
// bitmap word, then writes it back. One request at a time; busy drops in the strobe cycle,
// so the next start is taken then. The receiver cannot stall results. After reset a clearing
// pass zeroes the bitmap, one word per cycle, with busy high; config always lands.
`default_nettype none

module bitmap_block_allocator_rollback import bab_pkg::*; #(
    parameter int NUM_BLOCKS      = 4096,
    parameter int MAX_FILE_BLOCKS = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_mode,
    input  wire logic [11:0] i_block_number,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [12:0] i_cfg_data,
    output logic             o_result_valid,
    output logic [11:0]      o_allocated_block,
    output logic [1:0]       o_status,
    output logic             o_block_is_used,
    output logic [12:0]      o_used_count
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    bab_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (i_mode),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    bab_dpath #(
        .NUM_BLOCKS      (NUM_BLOCKS),
        .MAX_FILE_BLOCKS (MAX_FILE_BLOCKS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_mode            (i_mode),
        .i_block_number    (i_block_number),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_data        (i_cfg_data),
        .o_res_vld         (o_result_valid),
        .o_allocated_block (o_allocated_block),
        .o_status          (o_status),
        .o_block_is_used   (o_block_is_used),
        .o_used_count      (o_used_count)
    );

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Testbench for the first-fit bitmap block allocator with claim rollback.
`timescale 1ns / 100ps

module tb;
    import bab_pkg::*;

    localparam int NUM_BLOCKS   = 4096;
    localparam int CLAIM_DEPTH  = 128 + 1;
    localparam int RANDOM_ITEMS = 1850;
    localparam int N_DIRECTED   = 28;
    localparam int TAIL_CYCLES  = 300;   // longest rollback walk plus margin

    // modes with no defined action
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;

    typedef struct packed {
        logic [11:0] blk;
        logic [1:0]  st;
        logic        bit_used;
        logic [12:0] cnt;
    } t_alloc_res;

    typedef struct packed {
        logic        is_wr;
        logic [12:0] total;
        logic [2:0]  mode;
        logic [11:0] blk;
        logic        typed;
        t_alloc_res  want;
    } t_stim_row;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        start          = 1'b0;
    logic [2:0]  i_mode         = '0;
    logic [11:0] i_block_number = '0;
    logic        i_cfg_valid    = 1'b0;
    logic [12:0] i_cfg_data     = '0;
    logic        busy;
    logic        o_cfg_ready;
    logic        o_result_valid;
    logic [11:0] o_allocated_block;
    logic [1:0]  o_status;
    logic        o_block_is_used;
    logic [12:0] o_used_count;

    bitmap_block_allocator_rollback u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_mode           (i_mode),
        .i_block_number   (i_block_number),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_result_valid   (o_result_valid),
        .o_allocated_block(o_allocated_block),
        .o_status         (o_status),
        .o_block_is_used  (o_block_is_used),
        .o_used_count     (o_used_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow allocator state
    logic        used_map [0:NUM_BLOCKS-1];
    logic [11:0] claims [0:CLAIM_DEPTH-1];
    int unsigned n_claims;
    int unsigned n_used;
    logic [12:0] cfg_total;

    t_alloc_res pending_results [$];
    int         n_requests;
    int         n_checked;
    int         n_errors;
    int         status_seen [0:3];
    int         n_rollbacks;
    bit         no_idle;

    function automatic int unsigned eff_total();
        return (cfg_total < NUM_BLOCKS) ? int'(cfg_total) : NUM_BLOCKS;
    endfunction

    function automatic void set_block(int unsigned b, logic val);
        if (used_map[b] != val) begin
            used_map[b] = val;
            if (val) n_used++;
            else n_used--;
        end
    endfunction

    // Applies one request to the shadow state and returns the result it should give.
    function automatic t_alloc_res predict_request(logic [2:0] m, logic [11:0] b);
        t_alloc_res  r;
        int          fb;
        int unsigned lim;
        r = '0;
        lim = eff_total();
        fb = -1;
        case (m)
            MODE_ALLOC: begin
                for (int unsigned k = 0; k < lim; k++) begin
                    if (!used_map[k]) begin
                        fb = k;
                        break;
                    end
                end
                // an empty search wins over a full claim list
                if (fb < 0) begin
                    r.st = ST_NO_FREE;
                end else if (n_claims >= CLAIM_DEPTH) begin
                    r.st = ST_LIST_FULL;
                end else begin
                    set_block(fb, 1'b1);
                    claims[n_claims] = 12'(fb);
                    n_claims++;
                    r.blk      = 12'(fb);
                    r.bit_used = 1'b1;
                end
            end
            MODE_FREE, MODE_USED, MODE_QUERY: begin
                if (b >= lim) begin
                    r.st = ST_RANGE;
                end else begin
                    if (m != MODE_QUERY) set_block(b, m == MODE_USED);
                    r.bit_used = used_map[b];
                end
            end
            MODE_BEGIN: n_claims = 0;
            MODE_ROLLBACK: begin
                // stale or repeated claims are freed once only; total is ignored here
                for (int unsigned k = 0; k < n_claims; k++) set_block(claims[k], 1'b0);
                n_claims = 0;
                n_rollbacks++;
            end
            default: ;
        endcase
        r.cnt = (n_used > USED_MAX) ? USED_MAX : 13'(n_used);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [11:0] pick_block();
        int unsigned lim;
        lim = eff_total();
        if (lim != 0 && $urandom_range(0, 3) != 0) return 12'($urandom_range(0, lim - 1));
        return 12'($urandom);
    endfunction

    function automatic logic [12:0] pick_total();
        case ($urandom_range(0, 11))
            0:       return 13'd0;
            1:       return 13'd1;
            2:       return TOTAL_RST;
            3:       return 13'h1FFF;
            4:       return 13'($urandom_range(4097, 8191));
            5:       return 13'($urandom_range(63, 65));
            6:       return 13'd4095;
            7, 8, 9: return 13'($urandom_range(2, 70));
            default: return 13'($urandom_range(1, 4096));
        endcase
    endfunction

    function automatic t_stim_row req(logic [2:0] m, logic [11:0] b);
        t_stim_row s;
        s = '0;
        s.mode = m;
        s.blk  = b;
        return s;
    endfunction

    function automatic t_stim_row req_exp(logic [2:0] m, logic [11:0] b, logic [11:0] gb,
                                          logic [1:0] st, logic u, logic [12:0] cnt);
        t_stim_row s;
        s = req(m, b);
        s.typed = 1'b1;
        s.want  = '{gb, st, u, cnt};
        return s;
    endfunction

    function automatic t_stim_row total_row(logic [12:0] v);
        t_stim_row s;
        s = '0;
        s.is_wr = 1'b1;
        s.total = v;
        return s;
    endfunction

    // start stays high across back-to-back requests
    task automatic issue(input logic [2:0] m, input logic [11:0] b,
                         input logic typed, input t_alloc_res want);
        int         gap;
        t_alloc_res r;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_mode         <= m;
        i_block_number <= b;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        r = predict_request(m, b);
        pending_results.push_back(typed ? want : r);
        n_requests++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // ends only after valid has dropped at a clock edge, so a following write starts on a fresh edge
    task automatic write_total(input logic [12:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_total = v;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_alloc_res w;
        if (i_rst_n && o_result_valid === 1'b1) begin
            n_checked++;
            if (o_status !== 2'bx && o_status !== 2'bz) status_seen[o_status]++;
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: unexpected result blk=%0d st=%0d used=%0b cnt=%0d",
                             o_allocated_block, o_status, o_block_is_used, o_used_count);
            end else begin
                w = pending_results.pop_front();
                if (o_allocated_block !== w.blk || o_status !== w.st ||
                    o_block_is_used !== w.bit_used || o_used_count !== w.cnt) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display({"ERROR: result %0d exp blk=%0d st=%0d used=%0b cnt=%0d",
                                  " got blk=%0d st=%0d used=%0b cnt=%0d"},
                                 n_checked, w.blk, w.st, w.bit_used, w.cnt,
                                 o_allocated_block, o_status, o_block_is_used, o_used_count);
                end
            end
        end
    end

    t_stim_row directed_rows [0:N_DIRECTED-1];

    initial begin
        int          n;
        int          pick;
        int          n_start;
        logic [2:0]  m;
        logic [12:0] v;

        for (int k = 0; k < NUM_BLOCKS; k++) used_map[k] = 1'b0;
        n_claims    = 0;
        n_used      = 0;
        cfg_total   = TOTAL_RST;
        n_requests  = 0;
        n_checked   = 0;
        n_errors    = 0;
        n_rollbacks = 0;
        no_idle     = 1'b0;
        for (int k = 0; k < 4; k++) status_seen[k] = 0;

        // block 0 is claimed twice; block 1 is freed before the rollback
        directed_rows = '{
            req_exp(MODE_QUERY,    12'd0,     12'd0, ST_OK,        1'b0, 13'd0),
            req_exp(MODE_QUERY,    12'hFFF,   12'd0, ST_OK,        1'b0, 13'd0),
            req_exp(MODE_ALLOC,    12'hFFF,   12'd0, ST_OK,        1'b1, 13'd1),
            req_exp(MODE_ALLOC,    12'd0,     12'd1, ST_OK,        1'b1, 13'd2),
            req_exp(MODE_FREE,     12'd0,     12'd0, ST_OK,        1'b0, 13'd1),
            req_exp(MODE_ALLOC,    12'd0,     12'd0, ST_OK,        1'b1, 13'd2),
            req_exp(MODE_USED,     12'hFFF,   12'd0, ST_OK,        1'b1, 13'd3),
            req_exp(MODE_USED,     12'hFFF,   12'd0, ST_OK,        1'b1, 13'd3),
            req_exp(MODE_FREE,     12'd1,     12'd0, ST_OK,        1'b0, 13'd2),
            req_exp(MODE_ROLLBACK, 12'd0,     12'd0, ST_OK,        1'b0, 13'd1),
            req_exp(MODE_SPARE6,   12'd0,     12'd0, ST_OK,        1'b0, 13'd1),
            req_exp(MODE_SPARE7,   12'hFFF,   12'd0, ST_OK,        1'b0, 13'd1),
            req_exp(MODE_BEGIN,    12'h555,   12'd0, ST_OK,        1'b0, 13'd1),
            req(MODE_QUERY, 12'hAAA),
            req(MODE_USED,  12'h555),
            req(MODE_FREE,  12'hFFF),
            total_row(13'd0),
            req_exp(MODE_ALLOC,    12'd0,     12'd0, ST_NO_FREE,   1'b0, 13'd1),
            req_exp(MODE_QUERY,    12'd0,     12'd0, ST_RANGE,     1'b0, 13'd1),
            req_exp(MODE_USED,     12'd0,     12'd0, ST_RANGE,     1'b0, 13'd1),
            total_row(13'h1FFF),
            req(MODE_QUERY, 12'hFFF),
            total_row(13'd1),
            req_exp(MODE_ALLOC,    12'd0,     12'd0, ST_OK,        1'b1, 13'd2),
            req_exp(MODE_ALLOC,    12'd0,     12'd0, ST_NO_FREE,   1'b0, 13'd2),
            req(MODE_FREE,  12'd0),
            total_row(TOTAL_RST),
            req(MODE_ROLLBACK, 12'd0)
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_wr) begin
                drain_results();
                write_total(directed_rows[k].total);
            end else begin
                issue(directed_rows[k].mode, directed_rows[k].blk,
                      directed_rows[k].typed, directed_rows[k].want);
            end
        end

        n_start = n_requests;
        while (n_requests - n_start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                drain_results();
                write_total(pick_total());
            end
            no_idle = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 29);
            if (pick == 0) begin
                // run the claim list past its depth, then undo it
                drain_results();
                v = $urandom_range(0, 1) ? 13'($urandom_range(129, 140))
                                         : 13'($urandom_range(200, 8191));
                write_total(v);
                issue(MODE_BEGIN, 12'($urandom), 1'b0, '0);
                n = $urandom_range(131, 136);
                repeat (n) issue(MODE_ALLOC, 12'($urandom), 1'b0, '0);
                issue(MODE_ROLLBACK, 12'($urandom), 1'b0, '0);
            end else if (pick < 10) begin
                n = $urandom_range(5, 30);
                repeat (n) issue(3'($urandom_range(0, 7)), pick_block(), 1'b0, '0);
            end else begin
                issue(MODE_BEGIN, 12'($urandom), 1'b0, '0);
                n = $urandom_range(1, 24);
                repeat (n) begin
                    if ($urandom_range(0, 3) != 0) begin
                        issue(MODE_ALLOC, 12'($urandom), 1'b0, '0);
                    end else begin
                        case ($urandom_range(0, 2))
                            0:       m = MODE_FREE;
                            1:       m = MODE_USED;
                            default: m = MODE_QUERY;
                        endcase
                        issue(m, pick_block(), 1'b0, '0);
                    end
                end
                case ($urandom_range(0, 2))
                    0:       issue(MODE_ROLLBACK, 12'($urandom), 1'b0, '0);
                    1:       issue(MODE_BEGIN, 12'($urandom), 1'b0, '0);
                    default: ;
                endcase
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            n_errors++;
            $display("ERROR: %0d results never arrived", pending_results.size());
        end

        $display("Checked %0d results for %0d requests, %0d rollbacks, %0d mismatches.",
                 n_checked, n_requests, n_rollbacks, n_errors);
        $display("Status mix: ok %0d, no free %0d, list full %0d, out of range %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Timeout waiting on the allocator");
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/bab_pkg.sv
hdl/bab_ctrl.sv
hdl/bab_dpath.sv
hdl/bitmap_block_allocator_rollback.sv
verif/tb.sv
